### hw/rtl/go_to_goal_heading_controller_core_defines.svh
// assertion macros used by the checker file
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_CORE_DEFINES_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_CORE_DEFINES_SVH

// implication in the same cycle, off while reset is high
`define GGH_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ggh assertion failed");

// implication on the next cycle, off while reset is high
`define GGH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ggh assertion failed");

// implication in the same cycle, also checked through reset
`define GGH_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("ggh assertion failed");

`endif

### hw/rtl/ggh_pkg.sv
// types and constants of the go-to-goal heading controller
package ggh_pkg;
   localparam int PX_W           = 12;
   localparam int POS_W          = 16;
   localparam int ANG_W          = 16;
   localparam int DIM_W          = 13;
   localparam int SPEED_W        = 8;
   localparam int DRIVE_W        = 9;
   localparam int CSR_IDX_W      = 8;
   localparam int FRAC_POS       = 11;
   localparam int ZW             = 20;
   localparam int ANGLE_W        = ZW - 3;
   localparam int ERR_W          = 18;
   localparam int CORDIC_STEPS   = 16;

   localparam logic signed [ERR_W-1:0] PI_Q13         = 18'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13     = 18'sd51472;
   localparam logic signed [ERR_W-1:0] TURN_LIMIT_Q13 = 18'sd2457;
   localparam logic signed [ZW-1:0]    HALF_PI_Q16    = 20'sd102944;
   localparam int FAR_SHIFT = 2 * FRAC_POS;

   localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 13'd1920;
   localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 13'd1080;
   localparam logic [SPEED_W-1:0] RST_FORWARD_SPEED = 8'd5;
   localparam logic [SPEED_W-1:0] RST_TURN_SPEED    = 8'd10;

   // arctangent of 2^-i in units of 2^-16 rad
   localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
      20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
      20'sd16,    20'sd8,     20'sd4,     20'sd2
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCREEN_WIDTH  = 8'd0,
      REG_SCREEN_HEIGHT = 8'd1,
      REG_FORWARD_SPEED = 8'd2,
      REG_TURN_SPEED    = 8'd3
   } csr_index_type;

   // control travelling beside each pipeline section
   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctl_type;
endpackage

### hw/rtl/ggh_if.sv
// word channels of the go-to-goal heading controller
interface ggh_req_if import ggh_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [PX_W-1:0]         target_px_x;
   logic [PX_W-1:0]         target_px_y;
   logic signed [POS_W-1:0] pose_x;
   logic signed [POS_W-1:0] pose_y;
   logic signed [ANG_W-1:0] pose_heading;
   modport source (output valid, target_px_x, target_px_y, pose_x, pose_y, pose_heading,
                   input ready);
   modport sink   (input valid, target_px_x, target_px_y, pose_x, pose_y, pose_heading,
                   output ready);
endinterface

interface ggh_rsp_if import ggh_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [SPEED_W-1:0]        linear_drive;
   logic signed [DRIVE_W-1:0] angular_drive;
   logic signed [ANG_W-1:0]   heading_error;
   modport source (output valid, linear_drive, angular_drive, heading_error, input ready);
   modport sink   (input valid, linear_drive, angular_drive, heading_error, output ready);
endinterface

interface ggh_csr_if import ggh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/ggh_div_pipe.sv
// two-lane pipelined restoring divider, one quotient bit per stage
module ggh_div_pipe import ggh_pkg::*; #(
   parameter int NUM_W  = 27,
   parameter int SIDE_W = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  stage_ctl_type     ctl_i,
   input  logic [NUM_W-1:0]  num_x_i,
   input  logic [NUM_W-1:0]  num_y_i,
   input  logic [DIM_W-1:0]  den_x_i,
   input  logic [DIM_W-1:0]  den_y_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              valid_o,
   output logic [NUM_W-1:0]  quo_x_o,
   output logic [NUM_W-1:0]  quo_y_o,
   output logic [SIDE_W-1:0] side_o
);
   logic [NUM_W-1:0]  valid_ff;
   logic [NUM_W-1:0]  num_x_ff [NUM_W];
   logic [NUM_W-1:0]  num_y_ff [NUM_W];
   logic [NUM_W-1:0]  quo_x_ff [NUM_W];
   logic [NUM_W-1:0]  quo_y_ff [NUM_W];
   logic [DIM_W-1:0]  rem_x_ff [NUM_W];
   logic [DIM_W-1:0]  rem_y_ff [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [NUM_W-1:0]  num_x, num_y, quo_x, quo_y;
      logic [DIM_W-1:0]  rem_x, rem_y;
      logic [SIDE_W-1:0] side;
      logic              valid;
      logic [DIM_W:0]    trial_x, trial_y;
      logic [DIM_W-1:0]  rem_x_in, rem_y_in;
      logic              bit_x, bit_y;

      if (s == 0) begin : g_first
         assign num_x = num_x_i;
         assign num_y = num_y_i;
         assign quo_x = '0;
         assign quo_y = '0;
         assign rem_x = '0;
         assign rem_y = '0;
         assign side  = side_i;
         assign valid = ctl_i.valid;
      end else begin : g_next
         assign num_x = num_x_ff[s-1];
         assign num_y = num_y_ff[s-1];
         assign quo_x = quo_x_ff[s-1];
         assign quo_y = quo_y_ff[s-1];
         assign rem_x = rem_x_ff[s-1];
         assign rem_y = rem_y_ff[s-1];
         assign side  = side_ff[s-1];
         assign valid = valid_ff[s-1];
      end

      always_comb begin
         trial_x  = {rem_x, num_x[NUM_W-1]};
         trial_y  = {rem_y, num_y[NUM_W-1]};
         bit_x    = (trial_x >= {1'b0, den_x_i});
         bit_y    = (trial_y >= {1'b0, den_y_i});
         rem_x_in = bit_x ? DIM_W'(trial_x - {1'b0, den_x_i}) : trial_x[DIM_W-1:0];
         rem_y_in = bit_y ? DIM_W'(trial_y - {1'b0, den_y_i}) : trial_y[DIM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ctl_i.advance) begin
            valid_ff[s] <= valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_i.advance) begin
            num_x_ff[s] <= num_x << 1;
            num_y_ff[s] <= num_y << 1;
            quo_x_ff[s] <= {quo_x[NUM_W-2:0], bit_x};
            quo_y_ff[s] <= {quo_y[NUM_W-2:0], bit_y};
            rem_x_ff[s] <= rem_x_in;
            rem_y_ff[s] <= rem_y_in;
            side_ff[s]  <= side;
         end
      end
   end

   assign valid_o = valid_ff[NUM_W-1];
   assign quo_x_o = quo_x_ff[NUM_W-1];
   assign quo_y_o = quo_y_ff[NUM_W-1];
   assign side_o  = side_ff[NUM_W-1];
endmodule

### hw/rtl/ggh_cordic_pipe.sv
// vectoring cordic, one iteration per stage
module ggh_cordic_pipe import ggh_pkg::*; #(
   parameter int CW     = 32,
   parameter int SIDE_W = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  stage_ctl_type        ctl_i,
   input  logic signed [CW-1:0] x_i,
   input  logic signed [CW-1:0] y_i,
   input  logic signed [ZW-1:0] z_i,
   input  logic [SIDE_W-1:0]    side_i,
   output logic                 valid_o,
   output logic signed [ZW-1:0] z_o,
   output logic [SIDE_W-1:0]    side_o
);
   logic [CORDIC_STEPS-1:0] valid_ff;
   logic signed [CW-1:0]    x_ff    [CORDIC_STEPS];
   logic signed [CW-1:0]    y_ff    [CORDIC_STEPS];
   logic signed [ZW-1:0]    z_ff    [CORDIC_STEPS];
   logic [SIDE_W-1:0]       side_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [CW-1:0] x, y, xs, ys;
      logic signed [ZW-1:0] z;
      logic [SIDE_W-1:0]    side;
      logic                 valid;

      if (i == 0) begin : g_first
         assign x     = x_i;
         assign y     = y_i;
         assign z     = z_i;
         assign side  = side_i;
         assign valid = ctl_i.valid;
      end else begin : g_next
         assign x     = x_ff[i-1];
         assign y     = y_ff[i-1];
         assign z     = z_ff[i-1];
         assign side  = side_ff[i-1];
         assign valid = valid_ff[i-1];
      end

      // floor shifts
      assign xs = x >>> i;
      assign ys = y >>> i;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ctl_i.advance) begin
            valid_ff[i] <= valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_i.advance) begin
            side_ff[i] <= side;
            if (y > 0) begin
               x_ff[i] <= x + ys;
               y_ff[i] <= y - xs;
               z_ff[i] <= z + ATAN_TAB[i];
            end else begin
               x_ff[i] <= x - ys;
               y_ff[i] <= y + xs;
               z_ff[i] <= z - ATAN_TAB[i];
            end
         end
      end
   end

   assign valid_o = valid_ff[CORDIC_STEPS-1];
   assign z_o     = z_ff[CORDIC_STEPS-1];
   assign side_o  = side_ff[CORDIC_STEPS-1];
endmodule

### hw/rtl/go_to_goal_heading_controller_core.sv
// go-to-goal bang-bang steering controller, top level
// path: stage 0, the divider stages, stages e, f and g, the cordic stages, stage h, output register
// throughput: one word per cycle while the output is not held; the bit-serial divider stages set the depth
// the whole pipeline holds while a finished result waits at the output register
// reset: synchronous, clears all valid bits and loads register reset values
module go_to_goal_heading_controller_core import ggh_pkg::*; #(
   parameter int WORLD_SPAN = 11
) (
   input  logic       clock,
   input  logic       reset,
   ggh_req_if.sink    req,
   ggh_rsp_if.source  rsp,
   ggh_csr_if.sink    csr
);
   // world frame scaling
   localparam int SPAN_W = $clog2(WORLD_SPAN + 1) + FRAC_POS;
   localparam int NUM_W  = PX_W + SPAN_W;
   localparam int DX_W   = NUM_W + 2;
   localparam int CW     = DX_W + 3;
   localparam int SQ_W   = 2 * DX_W + 1;
   localparam int DSIDE_W = 2 * POS_W + ANG_W;
   localparam int CSIDE_W = ANG_W + 2;
   localparam logic [SPAN_W-1:0] SPAN = SPAN_W'(WORLD_SPAN << FRAC_POS);
   localparam logic [SQ_W-1:0] FAR_LIMIT = SQ_W'(1) << FAR_SHIFT;

   // configuration registers
   logic [DIM_W-1:0]   screen_width_ff, screen_height_ff;
   logic [SPEED_W-1:0] forward_speed_ff, turn_speed_ff;
   logic [DIM_W-1:0]   den_x, den_y;

   // global pipeline enable: move while the output register is free or drained
   logic          advance;
   logic          rsp_valid_ff;
   stage_ctl_type ctl;

   // stage 0: pixel times span
   logic                    s0_valid_ff;
   logic [NUM_W-1:0]        s0_num_x_ff, s0_num_y_ff;
   logic [DSIDE_W-1:0]      s0_side_ff;

   // divider outputs
   logic                    dv_valid;
   logic [NUM_W-1:0]        dv_quo_x, dv_quo_y;
   logic [DSIDE_W-1:0]      dv_side;
   stage_ctl_type           dv_ctl;

   // stage e: offsets to target
   logic                    se_valid_ff;
   logic signed [DX_W-1:0]  se_dx_ff, se_dy_ff;
   logic signed [ANG_W-1:0] se_heading_ff;
   logic signed [DX_W-1:0]  se_dx_in, se_dy_in;

   // stage f: squares
   logic                    sf_valid_ff;
   logic signed [DX_W-1:0]  sf_dx_ff, sf_dy_ff;
   logic signed [ANG_W-1:0] sf_heading_ff;
   logic [SQ_W-1:0]         sf_sq_x_ff, sf_sq_y_ff;

   // stage g: distance test and quadrant pre-rotation
   logic                    sg_valid_ff;
   logic signed [CW-1:0]    sg_x_ff, sg_y_ff;
   logic signed [ZW-1:0]    sg_z_ff;
   logic [CSIDE_W-1:0]      sg_side_ff;
   logic signed [CW-1:0]    sg_x_in, sg_y_in, dx_ext, dy_ext;
   logic signed [ZW-1:0]    sg_z_in;
   logic                    sg_far_in, sg_zero_in;

   // cordic outputs
   logic                    cd_valid;
   logic signed [ZW-1:0]    cd_z;
   logic [CSIDE_W-1:0]      cd_side;
   stage_ctl_type           cd_ctl;

   // stage h: wrapped heading error
   logic                    sh_valid_ff;
   logic signed [ERR_W-1:0] sh_err_ff;
   logic                    sh_far_ff;
   logic signed [ZW-1:0]    z_rnd;
   logic signed [ANGLE_W-1:0] angle;
   logic signed [ERR_W-1:0] err_raw, sh_err_in;
   logic                    cd_far, cd_zero;
   logic signed [ANG_W-1:0] cd_heading;

   // output register
   logic [SPEED_W-1:0]        rsp_linear_ff;
   logic signed [DRIVE_W-1:0] rsp_angular_ff;
   logic signed [ANG_W-1:0]   rsp_error_ff;
   logic signed [DRIVE_W-1:0] rsp_angular_in;

   // ---------------- configuration port ----------------
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= RST_SCREEN_WIDTH;
         screen_height_ff <= RST_SCREEN_HEIGHT;
         forward_speed_ff <= RST_FORWARD_SPEED;
         turn_speed_ff    <= RST_TURN_SPEED;
      end else if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            REG_SCREEN_WIDTH:  screen_width_ff  <= csr.data;
            REG_SCREEN_HEIGHT: screen_height_ff <= csr.data;
            REG_FORWARD_SPEED: forward_speed_ff <= csr.data[SPEED_W-1:0];
            REG_TURN_SPEED:    turn_speed_ff    <= csr.data[SPEED_W-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // a zero screen size divides as one
   assign den_x = (screen_width_ff == '0)  ? DIM_W'(1) : screen_width_ff;
   assign den_y = (screen_height_ff == '0) ? DIM_W'(1) : screen_height_ff;

   // ---------------- flow control ----------------
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;
   assign ctl       = '{advance: advance, valid: s0_valid_ff};

   // ---------------- stage 0 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_num_x_ff <= NUM_W'(req.target_px_x) * NUM_W'(SPAN);
         s0_num_y_ff <= NUM_W'(req.target_px_y) * NUM_W'(SPAN);
         s0_side_ff  <= {req.pose_x, req.pose_y, req.pose_heading};
      end
   end

   // ---------------- pixel to world division ----------------
   ggh_div_pipe #(
      .NUM_W  (NUM_W),
      .SIDE_W (DSIDE_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl_i   (ctl),
      .num_x_i (s0_num_x_ff),
      .num_y_i (s0_num_y_ff),
      .den_x_i (den_x),
      .den_y_i (den_y),
      .side_i  (s0_side_ff),
      .valid_o (dv_valid),
      .quo_x_o (dv_quo_x),
      .quo_y_o (dv_quo_y),
      .side_o  (dv_side)
   );

   assign dv_ctl = '{advance: advance, valid: dv_valid};

   // ---------------- stage e: dx, dy with y flipped ----------------
   always_comb begin
      se_dx_in = $signed({2'b00, dv_quo_x})
               - DX_W'($signed(dv_side[DSIDE_W-1 -: POS_W]));
      se_dy_in = $signed({2'b00, NUM_W'(SPAN)}) - $signed({2'b00, dv_quo_y})
               - DX_W'($signed(dv_side[ANG_W +: POS_W]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         se_valid_ff <= 1'b0;
      end else if (dv_ctl.advance) begin
         se_valid_ff <= dv_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         se_dx_ff      <= se_dx_in;
         se_dy_ff      <= se_dy_in;
         se_heading_ff <= $signed(dv_side[ANG_W-1:0]);
      end
   end

   // ---------------- stage f: squares ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sf_valid_ff <= 1'b0;
      end else if (advance) begin
         sf_valid_ff <= se_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sf_sq_x_ff    <= SQ_W'(se_dx_ff * se_dx_ff);
         sf_sq_y_ff    <= SQ_W'(se_dy_ff * se_dy_ff);
         sf_dx_ff      <= se_dx_ff;
         sf_dy_ff      <= se_dy_ff;
         sf_heading_ff <= se_heading_ff;
      end
   end

   // ---------------- stage g: distance test, pre-rotation ----------------
   always_comb begin
      dx_ext     = CW'(sf_dx_ff);
      dy_ext     = CW'(sf_dy_ff);
      sg_far_in  = (sf_sq_x_ff + sf_sq_y_ff) > FAR_LIMIT;
      sg_zero_in = (sf_dx_ff == '0) && (sf_dy_ff == '0);
      // left half plane turned by a quarter so the vectoring converges
      priority if (sf_dx_ff >= 0) begin
         sg_x_in = dx_ext;
         sg_y_in = dy_ext;
         sg_z_in = '0;
      end else if (sf_dy_ff >= 0) begin
         sg_x_in = dy_ext;
         sg_y_in = -dx_ext;
         sg_z_in = HALF_PI_Q16;
      end else begin
         sg_x_in = -dy_ext;
         sg_y_in = dx_ext;
         sg_z_in = -HALF_PI_Q16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sg_valid_ff <= 1'b0;
      end else if (advance) begin
         sg_valid_ff <= sf_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sg_x_ff    <= sg_x_in;
         sg_y_ff    <= sg_y_in;
         sg_z_ff    <= sg_z_in;
         sg_side_ff <= {sg_far_in, sg_zero_in, sf_heading_ff};
      end
   end

   // ---------------- bearing ----------------
   ggh_cordic_pipe #(
      .CW     (CW),
      .SIDE_W (CSIDE_W)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl_i   ('{advance: advance, valid: sg_valid_ff}),
      .x_i     (sg_x_ff),
      .y_i     (sg_y_ff),
      .z_i     (sg_z_ff),
      .side_i  (sg_side_ff),
      .valid_o (cd_valid),
      .z_o     (cd_z),
      .side_o  (cd_side)
   );

   assign cd_ctl = '{advance: advance, valid: cd_valid};

   // ---------------- stage h: round and wrap ----------------
   always_comb begin
      cd_far     = cd_side[CSIDE_W-1];
      cd_zero    = cd_side[CSIDE_W-2];
      cd_heading = $signed(cd_side[ANG_W-1:0]);
      z_rnd      = (cd_z + ZW'(4)) >>> 3;
      // target on the robot gives a bearing of zero
      angle      = cd_zero ? '0 : z_rnd[ANGLE_W-1:0];
      err_raw    = ERR_W'(angle) - ERR_W'(cd_heading);
      priority if (err_raw < -PI_Q13) begin
         sh_err_in = err_raw + TWO_PI_Q13;
      end else if (err_raw > PI_Q13) begin
         sh_err_in = err_raw - TWO_PI_Q13;
      end else begin
         sh_err_in = err_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_valid_ff <= 1'b0;
      end else if (cd_ctl.advance) begin
         sh_valid_ff <= cd_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sh_err_ff <= sh_err_in;
         sh_far_ff <= cd_far;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      if (sh_err_ff > TURN_LIMIT_Q13) begin
         rsp_angular_in = DRIVE_W'(turn_speed_ff);
      end else if (sh_err_ff < -TURN_LIMIT_Q13) begin
         rsp_angular_in = -DRIVE_W'(turn_speed_ff);
      end else begin
         rsp_angular_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sh_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_linear_ff  <= sh_far_ff ? forward_speed_ff : '0;
         rsp_angular_ff <= rsp_angular_in;
         rsp_error_ff   <= sh_err_ff[ANG_W-1:0];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.linear_drive  = rsp_linear_ff;
   assign rsp.angular_drive = rsp_angular_ff;
   assign rsp.heading_error = rsp_error_ff;
endmodule

### hw/rtl/ggh_checker.sv
// port-level checks of the controller, bound to the top level
`include "go_to_goal_heading_controller_core_defines.svh"

module ggh_checker import ggh_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [SPEED_W-1:0]        rsp_linear_drive,
   input logic signed [DRIVE_W-1:0] rsp_angular_drive,
   input logic signed [ANG_W-1:0]   rsp_heading_error
);
   localparam logic signed [ANG_W-1:0] LIMIT = ANG_W'(TURN_LIMIT_Q13);

   `GGH_ASSERT_ALWAYS(a_no_word_after_reset, clock, $past(reset), !rsp_valid)
   `GGH_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_linear_drive) && $stable(rsp_heading_error))
   `GGH_ASSERT_SAME(a_turn_left_large, clock, reset, rsp_valid && (rsp_angular_drive > 0), rsp_heading_error > LIMIT)
   `GGH_ASSERT_SAME(a_turn_right_large, clock, reset, rsp_valid && (rsp_angular_drive < 0), rsp_heading_error < -LIMIT)
endmodule

bind go_to_goal_heading_controller_core ggh_checker u_ggh_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_linear_drive  (rsp.linear_drive),
   .rsp_angular_drive (rsp.angular_drive),
   .rsp_heading_error (rsp.heading_error)
);
